// ===== sv/ulte_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulte_pkg
// Shared field widths, payload types and operation codes of the unsorted
// list table engine.
// ----------------------------------------------------------------------------
package ulte_pkg;

	// fixed field widths of the command, response and configuration words
	localparam int MODE_W  = 3;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 8;
	localparam int CNT_W   = 9;
	localparam int CAP_W   = 9;

	// capacity after reset, before any clamp to the table depth
	localparam int CAP_RESET = 256;

	typedef logic        [MODE_W-1:0]  mode_t;
	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic        [POS_W-1:0]   pos_t;
	typedef logic        [CNT_W-1:0]   cnt_t;
	typedef logic        [CAP_W-1:0]   cap_t;

	// operation codes carried in the mode field
	localparam mode_t MODE_INSERT    = 3'd0;
	localparam mode_t MODE_DEL_SWAP  = 3'd1;
	localparam mode_t MODE_DEL_SHIFT = 3'd2;
	localparam mode_t MODE_READ      = 3'd3;
	localparam mode_t MODE_SEARCH    = 3'd4;
	localparam mode_t MODE_REMOVE    = 3'd5;

endpackage

// ===== sv/ulte_cmd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulte_cmd_if
// Command channel: valid/ready handshake carrying one operation word.
// ----------------------------------------------------------------------------
interface ulte_cmd_if
	import ulte_pkg::*;
();
	logic   valid;
	logic   ready;
	mode_t  mode;
	value_t value;
	pos_t   position;

	modport source (output valid, output mode, output value, output position, input ready);
	modport sink (input valid, input mode, input value, input position, output ready);
endinterface

// ===== sv/ulte_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulte_rsp_if
// Response channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface ulte_rsp_if
	import ulte_pkg::*;
();
	logic   valid;
	logic   ready;
	logic   ok;
	value_t data_out;
	cnt_t   removed_count;
	cnt_t   length;

	modport source (output valid, output ok, output data_out, output removed_count,
		output length, input ready);
	modport sink (input valid, input ok, input data_out, input removed_count,
		input length, output ready);
endinterface

// ===== sv/ulte_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulte_mem
// Entry storage: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ulte_mem #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_WIDTH-1:0]    rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_WIDTH-1:0]    wr_data
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule

// ===== sv/ulte_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulte_ctrl
// Operation sequencer: takes a command word, walks the entry memory with a
// registered read pipeline, writes back moved entries, and holds the result
// word in an output register.
// ----------------------------------------------------------------------------
module ulte_ctrl
	import ulte_pkg::*;
#(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [$clog2(DEPTH+1)-1:0] cap_lim,
	ulte_cmd_if.sink                   cmd,
	ulte_rsp_if.source                 rsp,
	output logic                       rd_en,
	output logic [$clog2(DEPTH)-1:0]   rd_addr,
	input  logic [DATA_WIDTH-1:0]      rd_data,
	output logic                       wr_en,
	output logic [$clog2(DEPTH)-1:0]   wr_addr,
	output logic [DATA_WIDTH-1:0]      wr_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > CAP_W) ? CW : CAP_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_SWP_A = 3'd2;
	localparam logic [2:0] ST_SWP_B = 3'd3;
	localparam logic [2:0] ST_RESP  = 3'd4;

	logic [2:0]            state_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         rptr_q;
	logic [CW-1:0]         end_q;
	logic [CW-1:0]         wptr_q;
	logic                  vld_s1;
	logic [AW-1:0]         idx_s1;
	logic                  rsp_vld_q;

	mode_t                 op_q;
	logic [DATA_WIDTH-1:0] key_q;
	logic [AW-1:0]         pos_q;
	logic                  res_ok_q;
	logic [DATA_WIDTH-1:0] res_data_q;
	logic [CW-1:0]         res_rem_q;
	logic                  ok_q;
	logic [DATA_WIDTH-1:0] dout_q;
	logic [CW-1:0]         rem_q;
	logic [CW-1:0]         len_q;

	logic                  cmd_fire;
	logic                  pos_ok;
	logic                  ins_ok;
	logic                  scan_issue;
	logic                  scan_done;
	logic                  rsp_load;
	logic [CW-1:0]         last_idx;
	logic [DATA_WIDTH-1:0] cmd_val;

	// handshake and decode
	assign cmd.ready  = (state_q == ST_IDLE);
	assign cmd_fire   = cmd.valid && cmd.ready;
	assign cmd_val    = DATA_WIDTH'($unsigned(cmd.value));
	assign pos_ok     = LW'(cmd.position) < LW'(count_q);
	assign ins_ok     = count_q < cap_lim;
	assign scan_issue = rptr_q < end_q;
	assign scan_done  = !scan_issue && !vld_s1;
	assign rsp_load   = (state_q == ST_RESP) && (!rsp_vld_q || rsp.ready);
	assign last_idx   = count_q - CW'(1);

	// memory port steering
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rptr_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = rd_data;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_fire && cmd.mode == MODE_INSERT && ins_ok) begin
					wr_en   = 1'b1;
					wr_addr = count_q[AW-1:0];
					wr_data = cmd_val;
				end
				if (cmd_fire && cmd.mode == MODE_DEL_SWAP && pos_ok) begin
					rd_en   = 1'b1;
					rd_addr = AW'(cmd.position);
				end
			end
			ST_SCAN: begin
				rd_en = scan_issue;
				// writes land below the read pointer, so no overlap with reads
				if (vld_s1 && op_q == MODE_DEL_SHIFT && idx_s1 != pos_q) begin
					wr_en   = 1'b1;
					wr_addr = idx_s1 - AW'(1);
				end
				if (vld_s1 && op_q == MODE_REMOVE && rd_data != key_q) begin
					wr_en   = 1'b1;
					wr_addr = wptr_q[AW-1:0];
				end
			end
			ST_SWP_A: begin
				rd_en   = 1'b1;
				rd_addr = last_idx[AW-1:0];
			end
			ST_SWP_B: begin
				wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			rptr_q    <= '0;
			end_q     <= '0;
			wptr_q    <= '0;
			vld_s1    <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					wptr_q <= '0;
					if (cmd_fire) begin
						state_q <= ST_RESP;
						unique case (cmd.mode)
							MODE_INSERT: begin
								if (ins_ok) begin
									count_q <= count_q + CW'(1);
								end
							end
							MODE_DEL_SWAP: begin
								if (pos_ok) begin
									state_q <= ST_SWP_A;
								end
							end
							MODE_DEL_SHIFT: begin
								if (pos_ok) begin
									rptr_q  <= CW'(cmd.position);
									end_q   <= count_q;
									state_q <= ST_SCAN;
								end
							end
							MODE_READ: begin
								if (pos_ok) begin
									rptr_q  <= CW'(cmd.position);
									end_q   <= CW'(cmd.position) + CW'(1);
									state_q <= ST_SCAN;
								end
							end
							MODE_SEARCH, MODE_REMOVE: begin
								rptr_q  <= '0;
								end_q   <= count_q;
								state_q <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					vld_s1 <= scan_issue;
					if (scan_issue) begin
						rptr_q <= rptr_q + CW'(1);
					end
					if (vld_s1 && op_q == MODE_REMOVE && rd_data != key_q) begin
						wptr_q <= wptr_q + CW'(1);
					end
					if (scan_done) begin
						if (op_q == MODE_DEL_SHIFT) begin
							count_q <= count_q - CW'(1);
						end
						if (op_q == MODE_REMOVE) begin
							count_q <= wptr_q;
						end
						state_q <= ST_RESP;
					end
				end
				ST_SWP_A: begin
					state_q <= ST_SWP_B;
				end
				ST_SWP_B: begin
					count_q <= count_q - CW'(1);
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// output register: a new word may load as the old one leaves
			if (rsp_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		idx_s1 <= rptr_q[AW-1:0];
		if (cmd_fire) begin
			op_q       <= cmd.mode;
			key_q      <= cmd_val;
			pos_q      <= AW'(cmd.position);
			res_ok_q   <= (cmd.mode == MODE_INSERT) && ins_ok;
			res_data_q <= '0;
			res_rem_q  <= '0;
		end
		if (state_q == ST_SCAN && vld_s1) begin
			unique case (op_q)
				MODE_READ: begin
					res_data_q <= rd_data;
					res_ok_q   <= 1'b1;
				end
				MODE_DEL_SHIFT: begin
					if (idx_s1 == pos_q) begin
						res_data_q <= rd_data;
						res_ok_q   <= 1'b1;
					end
				end
				MODE_SEARCH: begin
					if (rd_data == key_q) begin
						res_ok_q <= 1'b1;
					end
				end
				MODE_REMOVE: begin
					if (rd_data == key_q) begin
						res_rem_q <= res_rem_q + CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
		if (state_q == ST_SCAN && scan_done && op_q == MODE_REMOVE) begin
			res_ok_q <= 1'b1;
		end
		if (state_q == ST_SWP_A) begin
			res_data_q <= rd_data;
		end
		if (state_q == ST_SWP_B) begin
			res_ok_q <= 1'b1;
		end
		if (rsp_load) begin
			ok_q   <= res_ok_q;
			dout_q <= res_data_q;
			rem_q  <= res_rem_q;
			len_q  <= count_q;
		end
	end

	// response word
	assign rsp.valid         = rsp_vld_q;
	assign rsp.ok            = ok_q;
	assign rsp.data_out      = VALUE_W'(dout_q);
	assign rsp.removed_count = CNT_W'(rem_q);
	assign rsp.length        = CNT_W'(len_q);

endmodule

// ===== sv/unsorted_list_table_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsorted_list_table_engine_core
// Bounded unsorted table of values with insert, delete (swap-last or
// order-keeping shift), read, search and remove-all.
//
//   channel   dir  handshake         word
//   cmd       in   valid/ready       mode, value, position
//   rsp       out  valid/ready       ok, data_out, removed_count, length
//   cfg       in   cfg_we            cfg_wdata -> capacity
//
// Search and remove-all walk every filled entry, shift delete the entries
// from the position to the last filled one; the single memory read port
// walks one entry per cycle. One command is in work at a time; the result
// register lets the next command start while a word waits on rsp. Reset
// empties the table at once (fill count only), so no clearing pass is
// needed; a stalled rsp holds the sequencer in its response state.
// ----------------------------------------------------------------------------
module unsorted_list_table_engine_core
	import ulte_pkg::*;
#(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  cap_t       cfg_wdata,
	ulte_cmd_if.sink   cmd,
	ulte_rsp_if.source rsp
);

	localparam int AW      = $clog2(DEPTH);
	localparam int CW      = $clog2(DEPTH + 1);
	localparam int LW      = (CW > CAP_W) ? CW : CAP_W;
	localparam int RST_LIM = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

	logic [CW-1:0]         cap_lim_q;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [DATA_WIDTH-1:0] rd_data;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;

	// capacity register, clamped to the table depth on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_lim_q <= CW'(RST_LIM);
		end else if (cfg_we) begin
			if (LW'(cfg_wdata) > LW'(DEPTH)) begin
				cap_lim_q <= CW'(DEPTH);
			end else begin
				cap_lim_q <= CW'(cfg_wdata);
			end
		end
	end

	ulte_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cap_lim (cap_lim_q),
		.cmd     (cmd),
		.rsp     (rsp),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	ulte_mem #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

endmodule
